FILE: hdl/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg: shared types and constants for the great-circle distance block.
// Holds fixed-point constants, the arctangent table and the stage structs.
// ----------------------------------------------------------------------------
package gcd_pkg;

  // Fraction bits of the input angles; the fold stage is sized for this value.
  localparam int unsigned ANGLE_FRAC_BITS = 22;
  localparam int unsigned QW = 34;
  localparam logic signed [QW-1:0] ONE_Q30 = 34'sd1073741824;
  localparam logic signed [QW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;
  localparam logic [25:0] RADIUS_RESET = 26'd6371000;

  typedef logic signed [QW-1:0] q_t;

  // Rotation cell state: running x, y, residual angle z, output signs.
  typedef struct packed {
    q_t   x;
    q_t   y;
    q_t   z;
    logic sneg;
    logic cneg;
  } rot_t;

  // Vectoring cell state.
  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
  } vec_t;

  // atan(2^-i) in Q30, round half up.
  function automatic q_t atan_q30(input int unsigned i);
    q_t r;
    r = '0;
    unique case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      10: r = 34'sd1048576;
      11: r = 34'sd524288;
      12: r = 34'sd262144;
      13: r = 34'sd131072;
      14: r = 34'sd65536;
      15: r = 34'sd32768;
      16: r = 34'sd16384;
      17: r = 34'sd8192;
      18: r = 34'sd4096;
      19: r = 34'sd2048;
      20: r = 34'sd1024;
      21: r = 34'sd512;
      22: r = 34'sd256;
      23: r = 34'sd128;
      24: r = 34'sd64;
      25: r = 34'sd32;
      26: r = 34'sd16;
      27: r = 34'sd8;
      28: r = 34'sd4;
      29: r = 34'sd2;
      30: r = 34'sd1;
      31: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic q_t clamp_q30(input q_t v);
    q_t r;
    r = v;
    if (v > ONE_Q30) r = ONE_Q30;
    else if (v < -ONE_Q30) r = -ONE_Q30;
    return r;
  endfunction

endpackage

FILE: hdl/gcd_rot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_rot_cell: one rotation-mode CORDIC iteration.
// Shift amount and table entry are fixed by the cell's place in the row.
// ----------------------------------------------------------------------------
module gcd_rot_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic          clk,
  input  logic          en,
  input  gcd_pkg::rot_t d_in,
  output gcd_pkg::rot_t d_out
);

  gcd_pkg::rot_t d_r;
  gcd_pkg::rot_t d_nxt;

  always_comb begin
    d_nxt = d_in;
    if (d_in.z >= 0) begin
      d_nxt.x = d_in.x - (d_in.y >>> STAGE);
      d_nxt.y = d_in.y + (d_in.x >>> STAGE);
      d_nxt.z = d_in.z - gcd_pkg::atan_q30(STAGE);
    end else begin
      d_nxt.x = d_in.x + (d_in.y >>> STAGE);
      d_nxt.y = d_in.y - (d_in.x >>> STAGE);
      d_nxt.z = d_in.z + gcd_pkg::atan_q30(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

FILE: hdl/gcd_vec_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_vec_cell: one vectoring-mode CORDIC iteration.
// Drives y toward zero and accumulates the angle in z.
// ----------------------------------------------------------------------------
module gcd_vec_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic          clk,
  input  logic          en,
  input  gcd_pkg::vec_t d_in,
  output gcd_pkg::vec_t d_out
);

  gcd_pkg::vec_t d_r;
  gcd_pkg::vec_t d_nxt;

  always_comb begin
    if (d_in.y > 0) begin
      d_nxt.x = d_in.x + (d_in.y >>> STAGE);
      d_nxt.y = d_in.y - (d_in.x >>> STAGE);
      d_nxt.z = d_in.z + gcd_pkg::atan_q30(STAGE);
    end else begin
      d_nxt.x = d_in.x - (d_in.y >>> STAGE);
      d_nxt.y = d_in.y + (d_in.x >>> STAGE);
      d_nxt.z = d_in.z - gcd_pkg::atan_q30(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  assign d_out = d_r;

endmodule

FILE: hdl/gcd_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_sqrt_cell: one digit step of a restoring integer square root.
// Two independent roots travel through the row side by side.
// ----------------------------------------------------------------------------
module gcd_sqrt_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [61:0] rem_a_in,
  input  logic [30:0] root_a_in,
  input  logic [61:0] rem_b_in,
  input  logic [30:0] root_b_in,
  output logic [61:0] rem_a_out,
  output logic [30:0] root_a_out,
  output logic [61:0] rem_b_out,
  output logic [30:0] root_b_out
);

  localparam int unsigned BIT = 30 - STAGE;

  logic [61:0] rem_a_r, rem_b_r, rem_a_nxt, rem_b_nxt;
  logic [30:0] root_a_r, root_b_r, root_a_nxt, root_b_nxt;
  logic [62:0] try_a, try_b;

  // Trial subtrahend is (2*root + 2^BIT) * 2^BIT.
  always_comb begin
    try_a = ({32'd0, root_a_in} << (BIT + 1)) + (63'd1 << (2 * BIT));
    try_b = ({32'd0, root_b_in} << (BIT + 1)) + (63'd1 << (2 * BIT));
    rem_a_nxt = rem_a_in;
    root_a_nxt = root_a_in;
    rem_b_nxt = rem_b_in;
    root_b_nxt = root_b_in;
    if ({1'b0, rem_a_in} >= try_a) begin
      rem_a_nxt = rem_a_in - try_a[61:0];
      root_a_nxt = root_a_in | (31'd1 << BIT);
    end
    if ({1'b0, rem_b_in} >= try_b) begin
      rem_b_nxt = rem_b_in - try_b[61:0];
      root_b_nxt = root_b_in | (31'd1 << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_a_r <= rem_a_nxt;
      root_a_r <= root_a_nxt;
      rem_b_r <= rem_b_nxt;
      root_b_r <= root_b_nxt;
    end
  end

  assign rem_a_out = rem_a_r;
  assign root_a_out = root_a_r;
  assign rem_b_out = rem_b_r;
  assign root_b_out = root_b_r;

endmodule

FILE: hdl/great_circle_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance: haversine distance between two points.
// Fully pipelined CORDIC and square-root chain, one word per cycle if not stalled.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   two latitudes, two longitudes
// out_     output     out_valid/out_stall distance, meters times 16
// cfg_     input      cfg_wr_en           sphere_radius
//
// One word is accepted every cycle while the output is not stalled. The
// latency is set by the rotation cell row, the 31-step square-root row,
// the vectoring row and the multiply stages.
// When out_stall is high with a valid result, the whole chain holds and
// in_stall rises, so no word is lost. Reset (rst_n, synchronous) clears the
// valid bits of the chain and loads the default radius of 6371000 m.
// ----------------------------------------------------------------------------
module great_circle_distance #(
  parameter int unsigned CORDIC_STAGES   = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [29:0] in_first_latitude,
  input  logic signed [30:0] in_first_longitude,
  input  logic signed [29:0] in_second_latitude,
  input  logic signed [30:0] in_second_longitude,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_distance,
  input  logic               cfg_wr_en,
  input  logic [25:0]        cfg_sphere_radius
);

  localparam int unsigned NS = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int unsigned FW = 32;  // folded angle width, covers 360 deg
  // Pre stages: 2, rotation: NS, post: 5, sqrt: 31, vectoring: NS, scale: 3.
  localparam int unsigned LAT = 2 + NS + 5 + 31 + NS + 3;

  logic [25:0] radius_r;
  logic        en;
  logic [LAT-1:0] vld_r;

  // The chain moves unless a finished result is being held.
  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= gcd_pkg::RADIUS_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_wr_en) radius_r <= cfg_sphere_radius;
      if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // ------------------------------------------------------------------------
  // Angle folding. Four angles: lat1, lat2 at FB and the two differences at
  // FB+1 (which halves them). Magnitude reduced modulo a full turn by a
  // compare-subtract ladder, then folded into a quarter turn.
  // ------------------------------------------------------------------------
  logic signed [31:0] ang_raw [4];
  logic [FW-1:0] mag_r [4];
  logic sneg0_r [4];
  logic [4:0] fbs [4];

  assign ang_raw[0] = 32'(in_first_latitude);
  assign ang_raw[1] = 32'(in_second_latitude);
  assign ang_raw[2] = 32'(in_first_latitude) - 32'(in_second_latitude);
  assign ang_raw[3] = 32'(in_first_longitude) - 32'(in_second_longitude);
  assign fbs[0] = 5'(gcd_pkg::ANGLE_FRAC_BITS);
  assign fbs[1] = 5'(gcd_pkg::ANGLE_FRAC_BITS);
  assign fbs[2] = 5'(gcd_pkg::ANGLE_FRAC_BITS + 1);
  assign fbs[3] = 5'(gcd_pkg::ANGLE_FRAC_BITS + 1);

  gcd_pkg::rot_t rot_in [4];
  gcd_pkg::rot_t rot_chain [4][NS+1];

  for (genvar g = 0; g < 4; g++) begin : g_fold
    localparam int unsigned FB = (g < 2) ? gcd_pkg::ANGLE_FRAC_BITS
                                         : gcd_pkg::ANGLE_FRAC_BITS + 1;
    localparam logic [39:0] FULL = 40'd360 << FB;
    localparam logic [39:0] HALF = 40'd180 << FB;
    localparam logic [39:0] QUAR = 40'd90 << FB;
    logic [39:0] a0, a1, af;
    logic sn, cn;
    logic [39:0] fold_r;
    logic sneg_r, cneg_r;
    logic [66:0] zprod;

    // Stage 1: magnitude. Values stay below four full turns at FB+1.
    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[g] <= ang_raw[g][31] ? FW'(-ang_raw[g]) : FW'(ang_raw[g]);
        sneg0_r[g] <= ang_raw[g][31];
      end
    end

    // Stage 2: modulo and fold, then degrees to radians.
    always_comb begin
      a0 = 40'(mag_r[g]);
      if (a0 >= (FULL << 1)) a0 = a0 - (FULL << 1);
      if (a0 >= FULL) a0 = a0 - FULL;
      a1 = a0;
      sn = sneg0_r[g];
      cn = 1'b0;
      if (a1 > HALF) begin
        a1 = FULL - a1;
        sn = !sn;
      end
      af = a1;
      if (af > QUAR) begin
        af = HALF - af;
        cn = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fold_r <= af;
        sneg_r <= sn;
        cneg_r <= cn;
      end
    end

    always_comb begin
      zprod = (67'(fold_r) * 67'(gcd_pkg::DEG_TO_RAD_Q32)
               + (67'd1 << (fbs[g] + 5'd1))) >> (fbs[g] + 5'd2);
      rot_in[g].x = gcd_pkg::CORDIC_GAIN_Q30;
      rot_in[g].y = '0;
      rot_in[g].z = gcd_pkg::q_t'(zprod);
      rot_in[g].sneg = sneg_r;
      rot_in[g].cneg = cneg_r;
    end

    assign rot_chain[g][0] = rot_in[g];
    for (genvar s = 0; s < NS; s++) begin : g_cell
      gcd_rot_cell #(.STAGE(s)) u_cell (
        .clk  (clk),
        .en   (en),
        .d_in (rot_chain[g][s]),
        .d_out(rot_chain[g][s+1])
      );
    end
  end

  // ------------------------------------------------------------------------
  // Sines and cosines, then the haversine term over five stages.
  // ------------------------------------------------------------------------
  gcd_pkg::q_t sn_q [4];
  gcd_pkg::q_t cs_q [4];
  for (genvar g = 0; g < 4; g++) begin : g_sc
    gcd_pkg::q_t xc, yc;
    assign xc = gcd_pkg::clamp_q30(rot_chain[g][NS].x);
    assign yc = gcd_pkg::clamp_q30(rot_chain[g][NS].y);
    assign sn_q[g] = rot_chain[g][NS].sneg ? -yc : yc;
    assign cs_q[g] = rot_chain[g][NS].cneg ? -xc : xc;
  end

  function automatic gcd_pkg::q_t mulq(input gcd_pkg::q_t a, input gcd_pkg::q_t b);
    logic signed [67:0] p;
    p = 68'(a) * 68'(b) + 68'sd536870912;
    return gcd_pkg::q_t'(p >>> 30);
  endfunction

  gcd_pkg::q_t c1_r, c2_r, sa_r, sb_r;
  gcd_pkg::q_t saa_r, cc_r, sbb_r;
  gcd_pkg::q_t saa2_r, ccs_r;
  gcd_pkg::q_t h_r;

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= cs_q[0];
      c2_r <= cs_q[1];
      sa_r <= sn_q[2];
      sb_r <= sn_q[3];
      saa_r <= mulq(sa_r, sa_r);
      cc_r <= mulq(c1_r, c2_r);
      sbb_r <= mulq(sb_r, sb_r);
      saa2_r <= saa_r;
      ccs_r <= mulq(cc_r, sbb_r);
      h_r <= saa2_r + ccs_r;
    end
  end

  // The clamp of h sits before the shift into the root stage.
  gcd_pkg::q_t h_cl;
  always_comb begin
    h_cl = h_r;
    if (h_r < 0) h_cl = '0;
    else if (h_r > gcd_pkg::ONE_Q30) h_cl = gcd_pkg::ONE_Q30;
  end

  logic [61:0] sq_rem_a [32];
  logic [61:0] sq_rem_b [32];
  logic [30:0] sq_root_a [32];
  logic [30:0] sq_root_b [32];
  logic [61:0] hr_in, hq_in;
  assign hr_in = {h_cl[31:0], 30'd0};
  assign hq_in = {32'(gcd_pkg::ONE_Q30 - h_cl), 30'd0};

  // The clamped term and its complement are registered once ahead of the
  // root row.
  logic [61:0] hr2_r, hq2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      hr2_r <= hr_in;
      hq2_r <= hq_in;
    end
  end

  assign sq_rem_a[0] = hr2_r;
  assign sq_rem_b[0] = hq2_r;
  assign sq_root_a[0] = '0;
  assign sq_root_b[0] = '0;

  for (genvar s = 0; s < 31; s++) begin : g_sqrt
    gcd_sqrt_cell #(.STAGE(s)) u_cell (
      .clk       (clk),
      .en        (en),
      .rem_a_in  (sq_rem_a[s]),
      .root_a_in (sq_root_a[s]),
      .rem_b_in  (sq_rem_b[s]),
      .root_b_in (sq_root_b[s]),
      .rem_a_out (sq_rem_a[s+1]),
      .root_a_out(sq_root_a[s+1]),
      .rem_b_out (sq_rem_b[s+1]),
      .root_b_out(sq_root_b[s+1])
    );
  end

  // ------------------------------------------------------------------------
  // Half central angle: atan2(sqrt(h), sqrt(1-h)) by the vectoring row.
  // ------------------------------------------------------------------------
  gcd_pkg::vec_t vec_chain [NS+1];
  assign vec_chain[0].x = gcd_pkg::q_t'(sq_root_b[31]);
  assign vec_chain[0].y = gcd_pkg::q_t'(sq_root_a[31]);
  assign vec_chain[0].z = '0;

  for (genvar s = 0; s < NS; s++) begin : g_vec
    gcd_vec_cell #(.STAGE(s)) u_cell (
      .clk  (clk),
      .en   (en),
      .d_in (vec_chain[s]),
      .d_out(vec_chain[s+1])
    );
  end

  // ------------------------------------------------------------------------
  // Scale by the radius and saturate.
  // ------------------------------------------------------------------------
  logic [31:0] theta_r;
  logic [57:0] prod_r;
  logic [31:0] dist_r;
  logic [33:0] dsh;

  always_ff @(posedge clk) begin
    if (en) begin
      theta_r <= vec_chain[NS].z[33] ? 32'd0 : vec_chain[NS].z[31:0];
      prod_r <= 58'(theta_r) * 58'(radius_r) + (58'd1 << 24);
      dist_r <= (dsh > 34'hFFFFFFFF) ? 32'hFFFFFFFF : dsh[31:0];
    end
  end
  assign dsh = prod_r[57:24] >> 1;

  assign out_valid = vld_r[LAT-1];
  assign out_distance = dist_r;

  // A held result freezes the whole chain.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_distance)))
    else $error("held result changed");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (radius_r == $past(cfg_sphere_radius)))
    else $error("radius write lost");

endmodule
